/* design/tpms_pkg.sv */
// shared constants, codes and types for the term proximity min span unit
`default_nettype none

package tpms_pkg;

	localparam int MAX_TERMS     = 8;
	localparam int MAX_POSITIONS = 256;
	localparam int POS_W         = 16;

	localparam int TERM_W   = $clog2(MAX_TERMS);
	localparam int CUR_W    = $clog2(MAX_POSITIONS);
	localparam int LEN_W    = CUR_W + 1;
	localparam int ADDR_W   = TERM_W + CUR_W;
	localparam int SPAN_W   = POS_W + 1;
	localparam int TCNT_W   = 4;
	localparam int DATA_W   = 32;
	localparam int PADDR_W  = 4;

	// register indexes
	localparam logic [1:0] REG_TERM_COUNT  = 2'd0;
	localparam logic [1:0] REG_TITLE_LIMIT = 2'd1;
	localparam logic [1:0] REG_TITLE_MODE  = 2'd2;

	// result status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_NARROW = 2'd2;
	localparam logic [1:0] STAT_LOAD   = 2'd3;

	typedef struct packed {
		logic [TCNT_W-1:0] term_count;
		logic [POS_W-1:0]  title_limit;
		logic              title_mode;
	} cfg_t;

endpackage

`default_nettype wire

/* design/tpms_regs.sv */
// configuration register file behind the apb-style port
`default_nettype none

module tpms_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           psel,
	input  wire logic                           penable,
	input  wire logic                           pwrite,
	input  wire logic [tpms_pkg::PADDR_W-1:0]   paddr,
	input  wire logic [tpms_pkg::DATA_W-1:0]    pwdata,
	output logic      [tpms_pkg::DATA_W-1:0]    prdata,
	output logic                                pready,
	output tpms_pkg::cfg_t                      cfg
);

	logic [tpms_pkg::TCNT_W-1:0] term_count_q;
	logic [tpms_pkg::POS_W-1:0]  title_limit_q;
	logic                        title_mode_q;
	logic                        wr;
	logic [1:0]                  idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_count_q  <= tpms_pkg::TCNT_W'(1);
			title_limit_q <= '0;
			title_mode_q  <= 1'b0;
		end else if (wr) begin
			case (idx)
				tpms_pkg::REG_TERM_COUNT:  term_count_q  <= pwdata[tpms_pkg::TCNT_W-1:0];
				tpms_pkg::REG_TITLE_LIMIT: title_limit_q <= pwdata[tpms_pkg::POS_W-1:0];
				tpms_pkg::REG_TITLE_MODE:  title_mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			tpms_pkg::REG_TERM_COUNT:
				prdata = tpms_pkg::DATA_W'(term_count_q);
			tpms_pkg::REG_TITLE_LIMIT:
				prdata = tpms_pkg::DATA_W'(title_limit_q);
			tpms_pkg::REG_TITLE_MODE:
				prdata = tpms_pkg::DATA_W'(title_mode_q);
			default:
				prdata = '0;
		endcase
	end

	assign cfg.term_count  = term_count_q;
	assign cfg.title_limit = title_limit_q;
	assign cfg.title_mode  = title_mode_q;

endmodule

`default_nettype wire

/* design/term_proximity_min_span_unit.sv */
// top level: position lists in one memory and the min span walk sequencer
// an append keeps busy low, so appends go one per cycle while no compute is running
// a compute steps through find and check in every walk round, then a load state with a memory read
// for every round but the last; the result word shows in the cycle busy falls
// an empty active list gives its result in the cycle after the command
// reset clears lengths, cursors, status and config; the position memory is not cleared
// the receiver cannot stall: done is a one-cycle strobe
`default_nettype none

module term_proximity_min_span_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic                                cmd,
	input  wire logic [tpms_pkg::TERM_W-1:0]         term,
	input  wire logic [tpms_pkg::POS_W-1:0]          position,
	output logic                                     done,
	output logic      [tpms_pkg::SPAN_W-1:0]         span,
	output logic                                     span_found,
	output logic      [tpms_pkg::LEN_W-1:0]          min_count,
	output logic      [tpms_pkg::TCNT_W-1:0]         title_terms,
	output logic      [1:0]                          status,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [tpms_pkg::PADDR_W-1:0]        paddr,
	input  wire logic [tpms_pkg::DATA_W-1:0]         pwdata,
	output logic      [tpms_pkg::DATA_W-1:0]         prdata,
	output logic                                     pready
);

	localparam int NT = tpms_pkg::MAX_TERMS;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_FIND  = 4'b0010,
		ST_CHECK = 4'b0100,
		ST_LOAD  = 4'b1000
	} state_t;

	tpms_pkg::cfg_t cfg;

	tpms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	state_t state_q;

	logic [tpms_pkg::LEN_W-1:0]  len_q   [NT];
	logic [tpms_pkg::CUR_W-1:0]  cur_q   [NT];
	logic [tpms_pkg::POS_W-1:0]  head_q  [NT];
	logic [tpms_pkg::POS_W-1:0]  first_q [NT];
	logic [tpms_pkg::POS_W-1:0]  last_q  [NT];
	logic [tpms_pkg::SPAN_W-1:0] best_q;
	logic                        found_q;
	logic                        load_err_q;
	logic [tpms_pkg::LEN_W-1:0]  min_cnt_q;
	logic [tpms_pkg::TCNT_W-1:0] ttl_q;
	logic [tpms_pkg::POS_W-1:0]  lo_q;
	logic [tpms_pkg::POS_W-1:0]  hi_q;
	logic [tpms_pkg::TERM_W-1:0] lo_idx_q;
	logic [tpms_pkg::POS_W-1:0]  rd_data_q;

	logic [tpms_pkg::POS_W-1:0]  mem [2**tpms_pkg::ADDR_W];

	logic                        done_q;
	logic [tpms_pkg::SPAN_W-1:0] span_q;
	logic                        span_found_q;
	logic [tpms_pkg::LEN_W-1:0]  min_count_q;
	logic [tpms_pkg::TCNT_W-1:0] title_terms_q;
	logic [1:0]                  status_q;

	// effective term count: zero acts as one, saturate at the list count
	logic [tpms_pkg::TCNT_W-1:0] tc;
	logic [NT-1:0]               active;

	always_comb begin
		if (cfg.term_count == '0)
			tc = tpms_pkg::TCNT_W'(1);
		else if (cfg.term_count > tpms_pkg::TCNT_W'(NT))
			tc = tpms_pkg::TCNT_W'(NT);
		else
			tc = cfg.term_count;
		for (int i = 0; i < NT; i++)
			active[i] = (tpms_pkg::TCNT_W'(i) < tc);
	end

	assign busy = !(state_q == ST_IDLE);

	// append path
	logic                        acc, app, cmp;
	logic [tpms_pkg::LEN_W-1:0]  tlen;
	logic                        bad;
	logic                        wr_en;
	logic [tpms_pkg::ADDR_W-1:0] wr_addr;

	assign acc     = start && !busy;
	assign app     = acc && !cmd;
	assign cmp     = acc && cmd;
	assign tlen    = len_q[term];
	assign bad     = (tlen >= tpms_pkg::LEN_W'(tpms_pkg::MAX_POSITIONS)) ||
	                 ((tlen != '0) && (position <= last_q[term]));
	assign wr_en   = app && !bad;
	assign wr_addr = {term, tlen[tpms_pkg::CUR_W-1:0]};

	// compute setup: shortest list, title terms, empty check
	logic [tpms_pkg::LEN_W-1:0]  cmin;
	logic [tpms_pkg::TCNT_W-1:0] ttl;
	logic                        empty;

	always_comb begin
		cmin  = tpms_pkg::LEN_W'(tpms_pkg::MAX_POSITIONS);
		ttl   = '0;
		empty = 1'b0;
		for (int i = 0; i < NT; i++) begin
			if (active[i]) begin
				if (len_q[i] < cmin)
					cmin = len_q[i];
				if (len_q[i] == '0)
					empty = 1'b1;
				else if (first_q[i] < cfg.title_limit)
					ttl = ttl + tpms_pkg::TCNT_W'(1);
			end
		end
	end

	// smallest and largest head, lowest index wins ties
	logic [tpms_pkg::POS_W-1:0]  lo_c, hi_c;
	logic [tpms_pkg::TERM_W-1:0] lo_idx_c;

	always_comb begin
		lo_c     = head_q[0];
		hi_c     = head_q[0];
		lo_idx_c = '0;
		for (int i = 1; i < NT; i++) begin
			if (active[i]) begin
				if (head_q[i] < lo_c) begin
					lo_c     = head_q[i];
					lo_idx_c = tpms_pkg::TERM_W'(i);
				end
				if (head_q[i] > hi_c)
					hi_c = head_q[i];
			end
		end
	end

	// round decision
	logic [tpms_pkg::SPAN_W-1:0] width;
	logic                        title_stop, narrow, list_end;
	logic [tpms_pkg::LEN_W-1:0]  next_cur;
	logic [tpms_pkg::SPAN_W-1:0] best_n;
	logic                        found_n;
	logic                        fin;
	logic                        rd_en;
	logic [tpms_pkg::ADDR_W-1:0] rd_addr;

	always_comb begin
		width      = {1'b0, hi_q} - {1'b0, lo_q} + tpms_pkg::SPAN_W'(1);
		title_stop = cfg.title_mode && (hi_q >= cfg.title_limit);
		narrow     = !title_stop && (width < tpms_pkg::SPAN_W'(tc));
		next_cur   = {1'b0, cur_q[lo_idx_q]} + tpms_pkg::LEN_W'(1);
		list_end   = next_cur >= len_q[lo_idx_q];
		best_n     = best_q;
		found_n    = found_q;
		if (!title_stop && !narrow) begin
			if (!found_q || width < best_q)
				best_n = width;
			found_n = 1'b1;
		end
		fin        = title_stop || narrow || list_end;
		rd_en      = (state_q == ST_CHECK) && !fin;
		rd_addr    = {lo_idx_q, next_cur[tpms_pkg::CUR_W-1:0]};
	end

	// position store: appends and walk reads never share a cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= position;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (wr_en) begin
			last_q[term] <= position;
			if (tlen == '0)
				first_q[term] <= position;
		end
		if (cmp) begin
			for (int i = 0; i < NT; i++)
				head_q[i] <= first_q[i];
			min_cnt_q <= cmin;
			ttl_q     <= ttl;
		end
		if (state_q == ST_FIND) begin
			lo_q     <= lo_c;
			hi_q     <= hi_c;
			lo_idx_q <= lo_idx_c;
		end
		if (state_q == ST_LOAD)
			head_q[lo_idx_q] <= rd_data_q;
	end

	// control and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			best_q        <= '0;
			found_q       <= 1'b0;
			load_err_q    <= 1'b0;
			done_q        <= 1'b0;
			span_q        <= '0;
			span_found_q  <= 1'b0;
			min_count_q   <= '0;
			title_terms_q <= '0;
			status_q      <= tpms_pkg::STAT_OK;
			for (int i = 0; i < NT; i++) begin
				len_q[i] <= '0;
				cur_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (app) begin
						if (bad)
							load_err_q <= 1'b1;
						else
							len_q[term] <= tlen + tpms_pkg::LEN_W'(1);
					end
					if (cmp) begin
						for (int i = 0; i < NT; i++)
							cur_q[i] <= '0;
						best_q  <= '0;
						found_q <= 1'b0;
						if (empty) begin
							// no walk, finish right away
							done_q        <= 1'b1;
							span_q        <= '0;
							span_found_q  <= 1'b0;
							min_count_q   <= cmin;
							title_terms_q <= ttl;
							status_q      <= load_err_q ? tpms_pkg::STAT_LOAD
							                            : tpms_pkg::STAT_EMPTY;
							load_err_q    <= 1'b0;
							for (int i = 0; i < NT; i++)
								len_q[i] <= '0;
						end else begin
							state_q <= ST_FIND;
						end
					end
				end
				ST_FIND: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					best_q  <= best_n;
					found_q <= found_n;
					if (fin) begin
						done_q        <= 1'b1;
						span_q        <= found_n ? best_n : '0;
						span_found_q  <= found_n;
						min_count_q   <= min_cnt_q;
						title_terms_q <= ttl_q;
						if (load_err_q)
							status_q <= tpms_pkg::STAT_LOAD;
						else if (narrow)
							status_q <= tpms_pkg::STAT_NARROW;
						else
							status_q <= tpms_pkg::STAT_OK;
						load_err_q <= 1'b0;
						best_q     <= '0;
						found_q    <= 1'b0;
						for (int i = 0; i < NT; i++) begin
							len_q[i] <= '0;
							cur_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end else begin
						cur_q[lo_idx_q] <= next_cur[tpms_pkg::CUR_W-1:0];
						state_q         <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_FIND;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done        = done_q;
	assign span        = span_q;
	assign span_found  = span_found_q;
	assign min_count   = min_count_q;
	assign title_terms = title_terms_q;
	assign status      = status_q;

	// a result word is only issued while idle: as the walk hands back to idle, or from idle for an empty list
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// every end of a walk issues a result
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("walk ended without a result");

	// a memory read is only consumed right after it was issued
	a_load_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> $past(rd_en))
		else $error("head load without a read");

	// a found window is never empty
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && span_found) |-> (span != '0))
		else $error("zero span reported as found");

	// reported list length never exceeds the list capacity
	a_min_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (min_count <= tpms_pkg::LEN_W'(tpms_pkg::MAX_POSITIONS)))
		else $error("min count above list capacity");

endmodule

`default_nettype wire
